// ===== design/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  // Default operand format
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Port widths fixed by the stream format
  localparam int PORT_W  = 32;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 4;

  // Operation kinds, coded as on the input tuser
  typedef enum logic [KIND_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_CONJ = 3'd5,
    OP_MAG  = 3'd6,
    OP_NOP  = 3'd7
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2,
    ST_RSV = 2'd3
  } status_t;

  // Iterative divide / square root unit states
  typedef enum logic [1:0] {
    IT_IDLE,
    IT_RUN,
    IT_DONE
  } it_state_t;

endpackage
`default_nettype wire

// ===== design/cau_front.sv =====
// Front end: accepts input beats, decodes the kind and flags a zero divisor.
`default_nettype none
module cau_front
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int PW         = KIND_W + 1 + 4 * DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [4*PORT_W-1:0]   in_tdata,
  input  wire logic [KIND_W-1:0]     in_tuser,
  output      logic                  q_valid,
  input  wire logic                  q_ready,
  output      logic [PW-1:0]         q_data
);

  logic [DATA_WIDTH-1:0] a_re, a_im, b_re, b_im;
  op_t                   op;
  logic                  dz;

  // Take the low operand bits of each field
  assign a_re = in_tdata[0*PORT_W +: DATA_WIDTH];
  assign a_im = in_tdata[1*PORT_W +: DATA_WIDTH];
  assign b_re = in_tdata[2*PORT_W +: DATA_WIDTH];
  assign b_im = in_tdata[3*PORT_W +: DATA_WIDTH];

  // Decode kind and spot a zero divisor
  always_comb begin
    op = op_t'(in_tuser);
    dz = (op == OP_DIV) && (b_re == '0) && (b_im == '0);
  end

  // Queue between front and back
  logic [PW-1:0] push_data;
  assign push_data = {b_im, b_re, a_im, a_re, dz, op};

  cau_fifo #(.WIDTH(PW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_valid  (in_tvalid),
    .wr_ready  (in_tready),
    .wr_data   (push_data),
    .rd_valid  (q_valid),
    .rd_ready  (q_ready),
    .rd_data   (q_data)
  );

endmodule
`default_nettype wire

// ===== design/cau_fifo.sv =====
// Small register queue that decouples the front from the back.
`default_nettype none
module cau_fifo
  import cau_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output      logic             wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output      logic             rd_valid,
  input  wire logic             rd_ready,
  output      logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign wr_ready = (cnt_r != CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = wr_en ? wp_r + PTR_W'(1) : wp_r;
    rp_nxt  = rd_en ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store beat payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/cau_back.sv =====
// Back end: operand register, multiplier stage, result stage with iterative divide/sqrt.
`default_nettype none
module cau_back
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int PW         = KIND_W + 1 + 4 * DATA_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  output      logic                q_ready,
  input  wire logic [PW-1:0]       q_data,
  output      logic                out_tvalid,
  input  wire logic                out_tready,
  output      logic [2*PORT_W-1:0] out_tdata,
  output      logic [STAT_W-1:0]   out_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int P   = 2 * W;          // product width
  localparam int SW  = P + 1;          // sum of two products
  localparam int NB  = P + FRAC_BITS;  // scaled dividend width
  localparam int CW  = $clog2(NB + 1);
  localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // Saturate a wide signed value: returns {flag, value}
  function automatic logic [W:0] sat_s(input logic signed [SW-1:0] x);
    logic [W:0] r;
    if (x > SMAX)      r = {1'b1, VMAX};
    else if (x < SMIN) r = {1'b1, VMIN};
    else               r = {1'b0, x[W-1:0]};
    return r;
  endfunction

  // ---------------- stage 1: operand register
  logic                v1_r;
  op_t                 op1_r;
  logic                dz1_r;
  logic signed [W-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  // ---------------- stage 2: products
  logic                v2_r;
  op_t                 op2_r;
  logic                dz2_r;
  logic signed [W-1:0] ar2_r, ai2_r, br2_r, bi2_r;
  logic signed [P-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;

  // ---------------- output register
  logic                out_v_r;
  logic [W-1:0]        ore_r, oim_r;
  status_t             ost_r;

  // ---------------- iterative unit
  it_state_t           it_r, it_nxt;
  logic [CW-1:0]       cnt_r;
  logic [NB-1:0]       dre_r, dim_r;
  logic [P-1:0]        rre_r, rim_r, den_r;
  logic [W:0]          qre_r, qim_r;
  logic                ovre_r, ovim_r, nre_r, nim_r;
  logic [P-1:0]        sres_r, sbit_r;

  logic is_iter, retire_ok, out_free, s2_free, s1_move, it_start;

  assign out_free  = !out_v_r || out_tready;
  assign is_iter   = v2_r && ((op2_r == OP_DIV && !dz2_r) || op2_r == OP_MAG);
  assign retire_ok = v2_r && (!is_iter || it_r == IT_DONE);
  assign s2_free   = !v2_r || (retire_ok && out_free);
  assign s1_move   = s2_free;
  assign q_ready   = !v1_r || s1_move;
  assign it_start  = is_iter && it_r == IT_IDLE;

  // Load operand register from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (q_ready) begin
      v1_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      op1_r <= op_t'(q_data[KIND_W-1:0]);
      dz1_r <= q_data[KIND_W];
      ar1_r <= q_data[KIND_W+1+0*W +: W];
      ai1_r <= q_data[KIND_W+1+1*W +: W];
      br1_r <= q_data[KIND_W+1+2*W +: W];
      bi1_r <= q_data[KIND_W+1+3*W +: W];
    end
  end

  // Multiply stage; the last two units square a for magnitude, b otherwise
  logic signed [W-1:0] m4x, m5x;
  assign m4x = (op1_r == OP_MAG) ? ar1_r : br1_r;
  assign m5x = (op1_r == OP_MAG) ? ai1_r : bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s1_move) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && v1_r) begin
      op2_r <= op1_r;
      dz2_r <= dz1_r;
      ar2_r <= ar1_r;
      ai2_r <= ai1_r;
      br2_r <= br1_r;
      bi2_r <= bi1_r;
      p0_r  <= P'(ar1_r * br1_r);
      p1_r  <= P'(ai1_r * bi1_r);
      p2_r  <= P'(ar1_r * bi1_r);
      p3_r  <= P'(ai1_r * br1_r);
      p4_r  <= P'(m4x * m4x);
      p5_r  <= P'(m5x * m5x);
    end
  end

  // Sums of products for multiply, divide and magnitude
  logic signed [SW-1:0] mre, mim, nre, nim;
  logic [P-1:0]         den, magre, magim;
  always_comb begin
    mre   = SW'(p0_r) - SW'(p1_r);
    mim   = SW'(p2_r) + SW'(p3_r);
    nre   = SW'(p0_r) + SW'(p1_r);
    nim   = SW'(p3_r) - SW'(p2_r);
    den   = P'(p4_r) + P'(p5_r);
    magre = nre[SW-1] ? P'(-nre) : P'(nre);
    magim = nim[SW-1] ? P'(-nim) : P'(nim);
  end

  // Iteration step values
  logic [P:0]    shre, shim, st;
  logic          qbre, qbim, sge;
  always_comb begin
    shre = {rre_r, dre_r[NB-1]};
    shim = {rim_r, dim_r[NB-1]};
    qbre = shre >= {1'b0, den_r};
    qbim = shim >= {1'b0, den_r};
    st   = {1'b0, sres_r} + {1'b0, sbit_r};
    sge  = {1'b0, rre_r} >= st;
  end

  // Iterative unit state
  always_comb begin
    it_nxt = it_r;
    case (it_r)
      IT_IDLE: if (it_start) it_nxt = IT_RUN;
      IT_RUN:  if (cnt_r == CW'(1)) it_nxt = IT_DONE;
      IT_DONE: if (retire_ok && out_free) it_nxt = IT_IDLE;
      default: it_nxt = IT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) it_r <= IT_IDLE;
    else        it_r <= it_nxt;
  end

  // Load or step divide / square root datapath
  always_ff @(posedge clk) begin
    if (it_start) begin
      den_r  <= den;
      nre_r  <= nre[SW-1];
      nim_r  <= nim[SW-1];
      dre_r  <= NB'(magre) << FRAC_BITS;
      dim_r  <= NB'(magim) << FRAC_BITS;
      qre_r  <= '0;
      qim_r  <= '0;
      ovre_r <= 1'b0;
      ovim_r <= 1'b0;
      sres_r <= '0;
      sbit_r <= P'(1) << (P - 2);
      if (op2_r == OP_MAG) begin
        rre_r <= den;
        cnt_r <= CW'(W);
      end else begin
        rre_r <= '0;
        cnt_r <= CW'(NB);
      end
      rim_r <= '0;
    end else if (it_r == IT_RUN) begin
      cnt_r <= cnt_r - CW'(1);
      if (op2_r == OP_MAG) begin
        sbit_r <= sbit_r >> 2;
        if (sge) begin
          rre_r  <= P'({1'b0, rre_r} - st);
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
      end else begin
        dre_r  <= dre_r << 1;
        dim_r  <= dim_r << 1;
        rre_r  <= qbre ? P'(shre - {1'b0, den_r}) : P'(shre);
        rim_r  <= qbim ? P'(shim - {1'b0, den_r}) : P'(shim);
        qre_r  <= {qre_r[W-1:0], qbre};
        qim_r  <= {qim_r[W-1:0], qbim};
        ovre_r <= ovre_r | qre_r[W];
        ovim_r <= ovim_r | qim_r[W];
      end
    end
  end

  // Saturate a quotient given its sign and magnitude
  function automatic logic [W:0] sat_q(input logic neg, input logic ov, input logic [W:0] q);
    logic [W:0] r;
    if (!neg) begin
      if (ov || q > {1'b0, VMAX}) r = {1'b1, VMAX};
      else                        r = {1'b0, q[W-1:0]};
    end else begin
      if (ov || q > {1'b0, VMIN}) r = {1'b1, VMIN};
      else                        r = {1'b0, W'(-q)};
    end
    return r;
  endfunction

  // Result selection
  logic [W:0]  rre, rim;
  logic        dz;
  always_comb begin
    rre = '0;
    rim = '0;
    dz  = 1'b0;
    case (op2_r)
      OP_ADD: begin
        rre = sat_s(SW'(ar2_r) + SW'(br2_r));
        rim = sat_s(SW'(ai2_r) + SW'(bi2_r));
      end
      OP_SUB: begin
        rre = sat_s(SW'(ar2_r) - SW'(br2_r));
        rim = sat_s(SW'(ai2_r) - SW'(bi2_r));
      end
      OP_MUL: begin
        rre = sat_s(mre >>> FRAC_BITS);
        rim = sat_s(mim >>> FRAC_BITS);
      end
      OP_DIV: begin
        if (dz2_r) begin
          dz = 1'b1;
        end else begin
          rre = sat_q(nre_r, ovre_r, qre_r);
          rim = sat_q(nim_r, ovim_r, qim_r);
        end
      end
      OP_NEG: begin
        rre = sat_s(-SW'(ar2_r));
        rim = sat_s(-SW'(ai2_r));
      end
      OP_CONJ: begin
        rre = {1'b0, ar2_r};
        rim = sat_s(-SW'(ai2_r));
      end
      OP_MAG: begin
        if (sres_r > P'(VMAX)) rre = {1'b1, VMAX};
        else                   rre = {1'b0, sres_r[W-1:0]};
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= retire_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && retire_ok) begin
      ore_r <= rre[W-1:0];
      oim_r <= rim[W-1:0];
      ost_r <= dz ? ST_DZ : ((rre[W] || rim[W]) ? ST_SAT : ST_OK);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {PORT_W'(signed'(oim_r)), PORT_W'(signed'(ore_r))};
  assign out_tuser  = ost_r;

endmodule
`default_nettype wire

// ===== design/complex_arithmetic_unit_top.sv =====
// Top level of the fixed-point complex arithmetic unit.
//
//  channel | dir | beat contents
//  in_     | in  | tdata: a_re, a_im, b_re, b_im; tuser: kind
//  out_    | out | tdata: r_re, r_im; tuser: status
//
// Add, sub, mul, negate and conjugate take one beat per cycle while the output
// is not stalled and no divide or magnitude is busy; a beat passes the queue, the
// operand register, the multipliers and the output register before out_tvalid rises.
// A divide by a nonzero divisor, or a magnitude, holds the result stage in the
// shared iterative divide/square-root unit until it is done; later beats wait.
// Reset (rst_n low, synchronous) empties the queue and pipeline.
// Either side may stall; the four-entry queue keeps the front accepting until it fills.
`default_nettype none
module complex_arithmetic_unit_top
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  input  wire logic [4*PORT_W-1:0] in_tdata,   // a_re, a_im, b_re, b_im
  input  wire logic [KIND_W-1:0]   in_tuser,   // kind
  output      logic                out_tvalid,
  input  wire logic                out_tready,
  output      logic [2*PORT_W-1:0] out_tdata,  // r_re, r_im
  output      logic [STAT_W-1:0]   out_tuser   // status
);

  localparam int PW = KIND_W + 1 + 4 * DATA_WIDTH;

  logic          q_valid, q_ready;
  logic [PW-1:0] q_data;

  cau_front #(.DATA_WIDTH(DATA_WIDTH), .PW(PW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data)
  );

  cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .PW(PW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
